FILE: src/jos_pkg.sv
package jos_pkg;

    localparam int LABEL_W   = 7;
    localparam int STEP_W    = 16;
    localparam int MOD_CNT_W = $clog2(STEP_W + 1);

    typedef struct packed {
        logic [LABEL_W-1:0] ring_size;
        logic [STEP_W-1:0]  step_count;
    } item_t;

    typedef struct packed {
        logic [LABEL_W-1:0] person_label;
        logic               last;
    } result_t;

    typedef struct packed {
        logic               start;
        logic [STEP_W-1:0]  dividend;
        logic [LABEL_W-1:0] divisor;
    } jos_mod_req_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [LABEL_W-1:0] remainder;
    } jos_mod_rsp_t;

endpackage

FILE: src/jos_mod.sv
module jos_mod (
    input  logic                 clk,
    input  logic                 rst_n,
    input  jos_pkg::jos_mod_req_t req,
    output jos_pkg::jos_mod_rsp_t rsp
);
    import jos_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [MOD_CNT_W-1:0] cnt_reg, cnt_next;
    logic [STEP_W-1:0]    dvd_reg, dvd_next;
    logic [LABEL_W-1:0]   div_reg, div_next;
    logic [LABEL_W-1:0]   rem_reg, rem_next;
    logic [LABEL_W-1:0]   trial;

    // remainder stays below the divisor, so its top bit is free for the shift
    assign trial = {rem_reg[LABEL_W-2:0], dvd_reg[STEP_W-1]};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = MOD_CNT_W'(STEP_W);
            dvd_next  = req.dividend;
            div_next  = req.divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            // restoring step: shift in one dividend bit, subtract if it fits
            rem_next = (trial >= div_reg) ? (trial - div_reg) : trial;
            dvd_next = {dvd_reg[STEP_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == MOD_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign rsp.busy      = busy_reg;
    assign rsp.done      = done_reg;
    assign rsp.remainder = rem_reg;

endmodule

FILE: src/jos_ring.sv
module jos_ring #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [AW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [AW-1:0] rdata
);

    logic [AW-1:0] mem [DEPTH];
    logic [AW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/josephus_elimination_order.sv
// Flow: write the ring of ring_size people, then per removal run the modulo unit,
// walk the links to the one removed and unlink it, then emit the survivor.
// One run at a time: item_ready is high only in the idle state, between runs; there
// is a single modulo unit and a successor memory with separate read and write ports.
// Reset: rst_n clears the sequencer and the result valid flag; the successor
// memory is not cleared, each run rewrites every entry it reads.
module josephus_elimination_order #(
    parameter int MAX_PEOPLE = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  jos_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_ready,
    output jos_pkg::result_t result
);
    import jos_pkg::*;

    localparam int PW = $clog2(MAX_PEOPLE);

    typedef enum logic [6:0] {
        S_IDLE      = 7'b0000001,
        S_FILL      = 7'b0000010,
        S_MOD_START = 7'b0000100,
        S_MOD_WAIT  = 7'b0001000,
        S_WALK      = 7'b0010000,
        S_REMOVE    = 7'b0100000,
        S_LAST      = 7'b1000000
    } state_t;

    state_t             state_reg, state_next;
    logic [LABEL_W-1:0] n_reg, n_next;
    logic [STEP_W-1:0]  k_reg, k_next;
    logic [PW-1:0]      idx_reg, idx_next;
    logic [PW-1:0]      cur_reg, cur_next;
    logic [PW-1:0]      pred_reg, pred_next;
    logic [LABEL_W-1:0] rem_reg, rem_next;
    logic [PW-1:0]      adv_reg, adv_next;
    logic               out_valid_reg, out_valid_next;
    result_t            out_data_reg, out_data_next;

    logic               slot_free;
    logic [LABEL_W-1:0] n_in;
    logic [PW-1:0]      n_last_idx;
    logic [LABEL_W-1:0] adv_full;
    logic               mem_we;
    logic [PW-1:0]      mem_waddr, mem_wdata, mem_raddr, mem_rdata;
    jos_mod_req_t       mod_req;
    jos_mod_rsp_t       mod_rsp;

    jos_mod u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mod_req),
        .rsp   (mod_rsp)
    );

    jos_ring #(
        .DEPTH (MAX_PEOPLE),
        .AW    (PW)
    ) u_ring (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign slot_free  = !out_valid_reg || result_ready;
    assign n_in       = (item.ring_size > LABEL_W'(MAX_PEOPLE)) ? LABEL_W'(MAX_PEOPLE)
                                                                 : item.ring_size;
    assign n_last_idx = PW'(n_reg - 1'b1);
    assign adv_full   = (mod_rsp.remainder == '0) ? (rem_reg - 1'b1)
                                                  : (mod_rsp.remainder - 1'b1);

    assign mod_req.start    = (state_reg == S_MOD_START);
    assign mod_req.dividend = k_reg;
    assign mod_req.divisor  = rem_reg;

    assign item_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        k_next         = k_reg;
        idx_next       = idx_reg;
        cur_next       = cur_reg;
        pred_next      = pred_reg;
        rem_next       = rem_reg;
        adv_next       = adv_reg;
        out_valid_next = out_valid_reg && !result_ready;
        out_data_next  = out_data_reg;
        mem_we         = 1'b0;
        mem_waddr      = idx_reg;
        mem_wdata      = '0;
        mem_raddr      = cur_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (item_valid && n_in != '0)
                begin
                    n_next     = n_in;
                    k_next     = item.step_count;
                    idx_next   = '0;
                    state_next = S_FILL;
                end
            end
            S_FILL:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg;
                mem_wdata = (idx_reg == n_last_idx) ? '0 : (idx_reg + 1'b1);
                idx_next  = idx_reg + 1'b1;
                if (idx_reg == n_last_idx)
                begin
                    cur_next   = '0;
                    pred_next  = n_last_idx;
                    rem_next   = n_reg;
                    state_next = (n_reg == LABEL_W'(1)) ? S_LAST : S_MOD_START;
                end
            end
            S_MOD_START:
            begin
                state_next = S_MOD_WAIT;
            end
            S_MOD_WAIT:
            begin
                if (mod_rsp.done)
                begin
                    adv_next   = adv_full[PW-1:0];
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (adv_reg == '0)
                begin
                    state_next = S_REMOVE;
                end
                else
                begin
                    // advance one link; read data already holds the successor
                    mem_raddr = mem_rdata;
                    pred_next = cur_reg;
                    cur_next  = mem_rdata;
                    adv_next  = adv_reg - 1'b1;
                end
            end
            S_REMOVE:
            begin
                if (slot_free)
                begin
                    out_valid_next             = 1'b1;
                    out_data_next.person_label = LABEL_W'(cur_reg) + 1'b1;
                    out_data_next.last         = 1'b0;
                    // unlink the removed person
                    mem_we     = 1'b1;
                    mem_waddr  = pred_reg;
                    mem_wdata  = mem_rdata;
                    cur_next   = mem_rdata;
                    rem_next   = rem_reg - 1'b1;
                    state_next = (rem_reg == LABEL_W'(2)) ? S_LAST : S_MOD_START;
                end
            end
            S_LAST:
            begin
                if (slot_free)
                begin
                    out_valid_next             = 1'b1;
                    out_data_next.person_label = LABEL_W'(cur_reg) + 1'b1;
                    out_data_next.last         = 1'b1;
                    state_next                 = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            cur_reg       <= '0;
            pred_reg      <= '0;
            rem_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cur_reg       <= cur_next;
            pred_reg      <= pred_next;
            rem_reg       <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        k_reg        <= k_next;
        idx_reg      <= idx_next;
        adv_reg      <= adv_next;
        out_data_reg <= out_data_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

    a_mod_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mod_rsp.done |-> (state_reg == S_MOD_WAIT))
        else $error("modulo done outside wait state");

    a_mod_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MOD_START) |=> mod_rsp.busy)
        else $error("modulo unit did not start");

    a_last_one_left: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LAST) |-> (rem_reg == LABEL_W'(1)))
        else $error("survivor emitted with more than one left");

    a_remove_emits: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_REMOVE) && slot_free) |=> (result_valid && !result.last))
        else $error("removal did not load a result");

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps

module tb;
    import jos_pkg::*;

    localparam int MAX_PEOPLE  = 64;
    localparam int CYCLE_LIMIT = 6_000_000;
    localparam int TAIL_CYCLES = 4000;

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_ready;
    item_t   item;
    logic    result_valid;
    logic    result_ready;
    result_t result;

    result_t pending_results[$];
    int      mismatch_count;
    int      cycle_count;
    bit      tx_idle;
    bit      rx_idle;
    int      rx_hold_request;

    logic [5:0] ring_next[MAX_PEOPLE];

    josephus_elimination_order #(
        .MAX_PEOPLE(MAX_PEOPLE)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result      (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    function automatic void predict_elimination(input item_t it);
        int unsigned size;
        int unsigned step;
        int unsigned left;
        int unsigned moves;
        int unsigned here;
        int unsigned prev;
        int unsigned p;
        result_t     r;
        size = it.ring_size;
        if (size == 0)
            return;
        if (size > MAX_PEOPLE)
            size = MAX_PEOPLE;
        step = it.step_count;
        for (p = 0; p < size; p++)
            ring_next[p] = (p + 1 == size) ? 6'd0 : 6'(p + 1);
        here = 0;
        prev = size - 1;
        left = size;
        while (left > 1)
        begin
            moves = ((step % left) + left - 1) % left;
            for (p = 0; p < moves; p++)
            begin
                prev = here;
                here = ring_next[here];
            end
            r.person_label = 7'(here + 1);
            r.last = 1'b0;
            pending_results.push_back(r);
            ring_next[prev] = ring_next[here];
            here = ring_next[prev];
            left--;
        end
        r.person_label = 7'(here + 1);
        r.last = 1'b1;
        pending_results.push_back(r);
    endfunction

    function automatic int pick_gap(input bit on);
        int r;
        if (!on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 4);
        return $urandom_range(20, 80);
    endfunction

    function automatic item_t random_run_item();
        item_t       it;
        int          r;
        int unsigned sat;
        r = $urandom_range(0, 99);
        if (r < 3)
            it.ring_size = 7'd0;
        else if (r < 88)
            it.ring_size = 7'($urandom_range(1, 16));
        else
            it.ring_size = 7'($urandom_range(17, 127));
        sat = (it.ring_size > MAX_PEOPLE) ? MAX_PEOPLE : it.ring_size;
        r = $urandom_range(0, 2);
        if (r == 0)
            it.step_count = 16'($urandom_range(0, 9));
        else if (r == 1 && sat != 0)
            it.step_count = 16'(sat * $urandom_range(0, 65535 / sat));
        else
            it.step_count = 16'($urandom_range(0, 65535));
        return it;
    endfunction

    function automatic void check_result(input result_t got);
        result_t exp;
        if (pending_results.size() == 0)
        begin
            $error("unexpected result: person_label=%0d last=%0b",
                   got.person_label, got.last);
            mismatch_count++;
            return;
        end
        exp = pending_results.pop_front();
        if (got.person_label !== exp.person_label)
        begin
            $error("person_label: expected %0d, actual %0d",
                   exp.person_label, got.person_label);
            mismatch_count++;
        end
        if (got.last !== exp.last)
        begin
            $error("last: expected %0b, actual %0b", exp.last, got.last);
            mismatch_count++;
        end
    endfunction

    initial
    begin
        int stall_left;
        stall_left = 0;
        result_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_valid && result_ready)
                check_result(result);
            if (rx_hold_request > 0)
            begin
                stall_left = rx_hold_request;
                rx_hold_request = 0;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                result_ready <= 1'b0;
            end
            else
            begin
                stall_left = pick_gap(rx_idle);
                result_ready <= (stall_left == 0);
            end
        end
    end

    task automatic send_item(input item_t it);
        int gap;
        gap = pick_gap(tx_idle);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        predict_elimination(it);
    endtask

    task automatic send_pair(input int size, input int step);
        item_t it;
        it.ring_size = 7'(size);
        it.step_count = 16'(step);
        send_item(it);
    endtask

    task automatic pause_until_drained();
        item_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic test_directed_extremes();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        send_pair(1, 1);
        send_pair(1, 0);
        send_pair(1, 65535);
        send_pair(0, 5);
        send_pair(0, 0);
        send_pair(2, 1);
        send_pair(2, 2);
        send_pair(2, 0);
        send_pair(3, 3);
        send_pair(3, 6);
        send_pair(5, 0);
        send_pair(7, 1);
        send_pair(7, 2);
        send_pair(10, 3);
        send_pair(64, 1);
        send_pair(64, 65535);
        send_pair(127, 3);
        send_pair(65, 64);
        send_pair(96, 0);
        send_pair(41, 43690);
        pause_until_drained();
    endtask

    task automatic test_random_back_to_back();
        int i;
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        for (i = 0; i < 30; i++)
            send_item(random_run_item());
        pause_until_drained();
    endtask

    task automatic test_random_with_gaps();
        int i;
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        for (i = 0; i < 52; i++)
            send_item(random_run_item());
        pause_until_drained();
    endtask

    task automatic test_receiver_hold_off();
        int i;
        tx_idle = 1'b0;
        rx_idle = 1'b1;
        rx_hold_request = 800;
        send_pair(12, 5);
        for (i = 0; i < 7; i++)
            send_item(random_run_item());
        pause_until_drained();
    endtask

    task automatic test_drain_pauses();
        int i;
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        for (i = 0; i < 30; i++)
        begin
            send_item(random_run_item());
            if (i % 6 == 2)
                pause_until_drained();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        mismatch_count = 0;
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        rx_hold_request = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_extremes();
        test_random_back_to_back();
        test_random_with_gaps();
        test_receiver_hold_off();
        test_drain_pauses();

        pause_until_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
